FILE: src/vcmn_pkg.sv
// ----------------------------------------------------------------------------
// vcmn_pkg
// Shared types and constants of the velocity command mux and normalizer.
// ----------------------------------------------------------------------------
package vcmn_pkg;

  localparam int unsigned CMD_W   = 16;
  localparam int unsigned MAG_W   = CMD_W + 1;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned PROD_W  = MAG_W + GAIN_W;
  localparam int unsigned AGE_W   = 12;
  localparam int unsigned PER_W   = 8;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned CFG_DW  = 24;

  localparam logic [AGE_W-1:0]  AGE_MAX   = '1;
  localparam logic [MAG_W-1:0]  Q14_ONE   = MAG_W'(16384);
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(32768);

  localparam logic [AGE_W-1:0]  RST_TIMEOUT  = AGE_W'(500);
  localparam logic [PER_W-1:0]  RST_PERIOD   = PER_W'(50);
  localparam logic [GAIN_W-1:0] RST_LIN_GAIN = GAIN_W'(1672370);
  localparam logic [GAIN_W-1:0] RST_ANG_GAIN = GAIN_W'(209046);

  typedef enum logic [1:0] {
    REQ_AUTO   = 2'd0,
    REQ_MANUAL = 2'd1,
    REQ_TICK   = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_AUTO   = 2'd1,
    SRC_MANUAL = 2'd2
  } src_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_NAV_TIMEOUT = 2'd0,
    CFG_PUB_PERIOD  = 2'd1,
    CFG_LIN_GAIN    = 2'd2,
    CFG_ANG_GAIN    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [AGE_W-1:0]  nav_timeout;
    logic [PER_W-1:0]  pub_period;
    logic [GAIN_W-1:0] lin_gain;
    logic [GAIN_W-1:0] ang_gain;
  } cfg_t;

  // selected command, as sign and magnitude per axis
  typedef struct packed {
    logic             vld;
    src_t             src;
    logic             lin_neg;
    logic [MAG_W-1:0] lin_mag;
    logic             ang_neg;
    logic [MAG_W-1:0] ang_mag;
  } sel_t;

endpackage

FILE: src/vcmn_select.sv
// ----------------------------------------------------------------------------
// vcmn_select
// Command store, age watchdog, publish divider and source selection.
// ----------------------------------------------------------------------------
module vcmn_select (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         acc,
  input  logic [1:0]                   req_type,
  input  logic [vcmn_pkg::CMD_W-1:0]   cmd_linear,
  input  logic [vcmn_pkg::CMD_W-1:0]   cmd_angular,
  input  vcmn_pkg::cfg_t               cfg,
  output vcmn_pkg::sel_t               sel
);
  import vcmn_pkg::*;

  logic [CMD_W-1:0] auto_lin_r, auto_lin_nxt;
  logic [CMD_W-1:0] auto_ang_r, auto_ang_nxt;
  logic             auto_pres_r, auto_pres_nxt;
  logic [AGE_W-1:0] auto_age_r, auto_age_nxt;
  logic [CMD_W-1:0] man_lin_r, man_lin_nxt;
  logic [CMD_W-1:0] man_ang_r, man_ang_nxt;
  logic             man_pres_r, man_pres_nxt;
  logic [PER_W-1:0] per_cnt_r, per_cnt_nxt;
  sel_t             sel_r, sel_nxt;

  logic [AGE_W-1:0] age_inc;
  logic [PER_W-1:0] cnt_inc;
  logic             publish;
  logic             fresh;
  logic [CMD_W-1:0] pick_lin, pick_ang;

  function automatic logic [MAG_W-1:0] abs_mag(input logic [CMD_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[CMD_W-1], v};
    return v[CMD_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

  always_comb begin
    age_inc  = (auto_age_r == AGE_MAX) ? auto_age_r : auto_age_r + AGE_W'(1);
    cnt_inc  = per_cnt_r + PER_W'(1);
    // zero period behaves like one
    publish  = (cnt_inc == '0) || (cnt_inc >= cfg.pub_period);
    fresh    = auto_pres_r && (age_inc < cfg.nav_timeout);

    auto_lin_nxt  = auto_lin_r;
    auto_ang_nxt  = auto_ang_r;
    auto_pres_nxt = auto_pres_r;
    auto_age_nxt  = auto_age_r;
    man_lin_nxt   = man_lin_r;
    man_ang_nxt   = man_ang_r;
    man_pres_nxt  = man_pres_r;
    per_cnt_nxt   = per_cnt_r;
    pick_lin      = '0;
    pick_ang      = '0;
    sel_nxt       = '0;
    sel_nxt.src   = SRC_NONE;

    if (acc) begin
      unique case (req_type)
        REQ_AUTO: begin
          auto_lin_nxt  = cmd_linear;
          auto_ang_nxt  = cmd_angular;
          auto_pres_nxt = 1'b1;
          auto_age_nxt  = '0;
        end
        REQ_MANUAL: begin
          man_lin_nxt  = cmd_linear;
          man_ang_nxt  = cmd_angular;
          man_pres_nxt = 1'b1;
        end
        REQ_TICK: begin
          auto_age_nxt = age_inc;
          per_cnt_nxt  = publish ? '0 : cnt_inc;
          if (publish) begin
            sel_nxt.vld = 1'b1;
            if (fresh) begin
              pick_lin    = auto_lin_r;
              pick_ang    = auto_ang_r;
              sel_nxt.src = SRC_AUTO;
              man_lin_nxt = '0;
              man_ang_nxt = '0;
            end else if (man_pres_r) begin
              pick_lin    = man_lin_r;
              pick_ang    = man_ang_r;
              sel_nxt.src = SRC_MANUAL;
            end
          end
        end
        default: ;
      endcase
    end

    sel_nxt.lin_neg = pick_lin[CMD_W-1];
    sel_nxt.lin_mag = abs_mag(pick_lin);
    sel_nxt.ang_neg = pick_ang[CMD_W-1];
    sel_nxt.ang_mag = abs_mag(pick_ang);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_lin_r  <= '0;
      auto_ang_r  <= '0;
      auto_pres_r <= 1'b0;
      auto_age_r  <= '0;
      man_lin_r   <= '0;
      man_ang_r   <= '0;
      man_pres_r  <= 1'b0;
      per_cnt_r   <= '0;
      sel_r       <= '0;
    end else if (en) begin
      auto_lin_r  <= auto_lin_nxt;
      auto_ang_r  <= auto_ang_nxt;
      auto_pres_r <= auto_pres_nxt;
      auto_age_r  <= auto_age_nxt;
      man_lin_r   <= man_lin_nxt;
      man_ang_r   <= man_ang_nxt;
      man_pres_r  <= man_pres_nxt;
      per_cnt_r   <= per_cnt_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign sel = sel_r;

endmodule

FILE: src/vcmn_scale.sv
// ----------------------------------------------------------------------------
// vcmn_scale
// One axis: multiply by Q16 gain, round half away, clamp to +/-1.0 in Q1.14.
// ----------------------------------------------------------------------------
module vcmn_scale (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          neg,
  input  logic [vcmn_pkg::MAG_W-1:0]    mag,
  input  logic [vcmn_pkg::GAIN_W-1:0]   gain,
  output logic [vcmn_pkg::CMD_W-1:0]    res
);
  import vcmn_pkg::*;

  localparam int unsigned Q_W = PROD_W - FRAC_W;

  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic [CMD_W-1:0]  res_r, res_nxt;

  logic [PROD_W-1:0] rnd;
  logic [Q_W-1:0]    q;
  logic [CMD_W-1:0]  qc;

  always_comb begin
    rnd = prod_r + ROUND_ADD;
    q   = rnd[PROD_W-1:FRAC_W];
    qc  = (q > Q_W'(Q14_ONE)) ? CMD_W'(Q14_ONE) : q[CMD_W-1:0];
    res_nxt = neg_r ? (~qc + CMD_W'(1)) : qc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(mag) * PROD_W'(gain);
      neg_r  <= neg;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

FILE: src/velocity_command_mux_normalizer.sv
// ----------------------------------------------------------------------------
// velocity_command_mux_normalizer
// Two-source velocity command selector with staleness watchdog and normalizer.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_tready is high. Autonomous and manual
// commands only update the stored state; a millisecond tick ages the
// autonomous command and steps the publish divider, and on the publish tick
// one result is presented at the output through three registers
// (select register, gain multiplier register, round/clamp output register).
// The whole pipeline moves together:
// when a result sits unconsumed at the output, in_tready drops in the same
// cycle, so throughput is one request per cycle whenever the sink keeps up.
// Configuration is a plain write port; writes are registered before use.
// ----------------------------------------------------------------------------
module velocity_command_mux_normalizer (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [15:0] cmd_linear, [31:16] cmd_angular
  input  logic [1:0]                  in_tuser,   // [1:0] req_type
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // [15:0] out_linear, [31:16] out_angular
  output logic [1:0]                  out_tuser,  // [1:0] out_source
  // configuration writes
  input  logic                        cfg_we,
  input  logic [vcmn_pkg::CFG_IW-1:0] cfg_index,
  input  logic [vcmn_pkg::CFG_DW-1:0] cfg_wdata
);
  import vcmn_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  sel_t             sel;
  logic             adv;
  logic             acc;
  logic             v2_r;
  src_t             src2_r;
  logic             vo_r;
  src_t             srco_r;
  logic [CMD_W-1:0] lin_res, ang_res;

  // whole pipeline advances unless a result waits at the output
  assign adv       = !vo_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  // configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NAV_TIMEOUT: cfg_nxt.nav_timeout = cfg_wdata[AGE_W-1:0];
        CFG_PUB_PERIOD:  cfg_nxt.pub_period  = cfg_wdata[PER_W-1:0];
        CFG_LIN_GAIN:    cfg_nxt.lin_gain    = cfg_wdata[GAIN_W-1:0];
        CFG_ANG_GAIN:    cfg_nxt.ang_gain    = cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nav_timeout <= RST_TIMEOUT;
      cfg_r.pub_period  <= RST_PERIOD;
      cfg_r.lin_gain    <= RST_LIN_GAIN;
      cfg_r.ang_gain    <= RST_ANG_GAIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage 1: state update and source selection
  vcmn_select u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .acc         (acc),
    .req_type    (in_tuser),
    .cmd_linear  (in_tdata[15:0]),
    .cmd_angular (in_tdata[31:16]),
    .cfg         (cfg_r),
    .sel         (sel)
  );

  // stages 2 and 3: per axis multiply, then round and clamp
  vcmn_scale u_scale_lin (
    .clk  (clk),
    .en   (adv),
    .neg  (sel.lin_neg),
    .mag  (sel.lin_mag),
    .gain (cfg_r.lin_gain),
    .res  (lin_res)
  );

  vcmn_scale u_scale_ang (
    .clk  (clk),
    .en   (adv),
    .neg  (sel.ang_neg),
    .mag  (sel.ang_mag),
    .gain (cfg_r.ang_gain),
    .res  (ang_res)
  );

  // valid and source follow the scaler stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v2_r <= sel.vld;
      vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      src2_r <= sel.src;
      srco_r <= src2_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {ang_res, lin_res};
  assign out_tuser  = srco_r;

`ifndef SYNTHESIS
  // no source selected means both axes are zero
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == SRC_NONE) |-> (out_tdata == 32'd0))
    else $error("source none with nonzero axes");

  // clamp keeps both axes within plus or minus one
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384) &&
                   ($signed(out_tdata[15:0]) >= -16'sd16384) &&
                   ($signed(out_tdata[31:16]) <= 16'sd16384) &&
                   ($signed(out_tdata[31:16]) >= -16'sd16384))
    else $error("normalized axis out of range");

  // command requests never start a result
  a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != REQ_TICK) |=> !sel.vld)
    else $error("result from a non-tick request");

  // a selected result reaches the output two stages later when unstalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    sel.vld && adv ##1 adv |=> out_tvalid)
    else $error("selected result lost in pipeline");
`endif

endmodule
